### hw/rtl/c3f_pkg.sv
// ----------------------------------------------------------------------------
// c3f_pkg
// Types, constants and register codes of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int PIXEL_BITS  = 16;
  localparam int COEF_BITS   = 8;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 13;
  localparam int HEIGHT_BITS = 16;
  localparam int KROW_BITS   = 3 * COEF_BITS;
  localparam int PROD_BITS   = PIXEL_BITS + COEF_BITS;
  localparam int COLSUM_BITS = PROD_BITS + 2;
  localparam int FULL_BITS   = COLSUM_BITS + 2;
  localparam int OUT_BITS    = 27;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

  // register reset values
  localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH   = 13'd640;
  localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT  = 16'd480;
  localparam logic [KROW_BITS-1:0]   RST_KERNEL_TOP    = 24'h010201;
  localparam logic [KROW_BITS-1:0]   RST_KERNEL_MIDDLE = 24'h020402;
  localparam logic [KROW_BITS-1:0]   RST_KERNEL_BOTTOM = 24'h010201;

  localparam logic [WIDTH_BITS-1:0]  MIN_WIDTH_VAL  = 13'd3;
  localparam logic [WIDTH_BITS-1:0]  MAX_WIDTH_VAL  = WIDTH_BITS'(MAX_WIDTH);
  localparam logic [HEIGHT_BITS-1:0] MIN_HEIGHT_VAL = 16'd3;

  typedef logic signed [PIXEL_BITS-1:0]  pixel_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [COLSUM_BITS-1:0] colsum_t;
  typedef logic signed [FULL_BITS-1:0]   full_sum_t;
  typedef logic signed [OUT_BITS-1:0]    out_sum_t;
  typedef logic [COL_BITS-1:0]           col_t;
  typedef logic [HEIGHT_BITS-1:0]        row_t;

  // one line buffer entry: the pixel two rows up and the one a row up
  typedef struct packed {
    pixel_t two_above;
    pixel_t above;
  } line_word_t;

  // load enables of the column cells
  typedef struct packed {
    logic shift;
    logic mult;
    logic sum;
  } cell_ctl_t;

  typedef struct packed {
    logic inner;
    logic last;
  } item_flags_t;

  function automatic coef_t coef_of(input logic [KROW_BITS-1:0] krow, input int idx);
    return coef_t'(krow[idx*COEF_BITS +: COEF_BITS]);
  endfunction

endpackage

`default_nettype wire

### hw/rtl/c3f_line_buf.sv
// ----------------------------------------------------------------------------
// c3f_line_buf
// Two line buffers held in one memory, one entry per column.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_line_buf (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire c3f_pkg::col_t      rd_addr,
  output c3f_pkg::line_word_t     rd_data,
  input  wire logic               wr_en,
  input  wire c3f_pkg::col_t      wr_addr,
  input  wire c3f_pkg::line_word_t wr_data
);
  import c3f_pkg::*;

  line_word_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/c3f_col_cell.sv
// ----------------------------------------------------------------------------
// c3f_col_cell
// One window column: holds three pixels, passes them to its neighbor,
// multiplies them by its kernel column and sums the column.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_col_cell (
  input  wire logic               clk,
  input  wire c3f_pkg::cell_ctl_t ctl,
  input  wire c3f_pkg::pixel_t    pix_in [3],
  input  wire c3f_pkg::coef_t     coef [3],
  output c3f_pkg::pixel_t         pix_out [3],
  output c3f_pkg::colsum_t        col_sum
);
  import c3f_pkg::*;

  pixel_t pix [3];
  prod_t  prod [3];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (ctl.shift) begin
        pix[k] <= pix_in[k];
      end
      if (ctl.mult) begin
        prod[k] <= prod_t'(pix[k]) * prod_t'(coef[k]);
      end
    end
    if (ctl.sum) begin
      col_sum <= colsum_t'(prod[0]) + colsum_t'(prod[1]) + colsum_t'(prod[2]);
    end
  end

  assign pix_out = pix;

endmodule

`default_nettype wire

### hw/rtl/conv3x3_image_filter_unit.sv
// ----------------------------------------------------------------------------
// conv3x3_image_filter_unit
// 3x3 convolution over a raster-order pixel stream with a programmable
// kernel of signed 8-bit coefficients, one result per input pixel.
// ----------------------------------------------------------------------------
//  channel  | signals                                     | direction
//  ---------+---------------------------------------------+----------
//  input    | in_valid, in_ready, pixel                   | in
//  result   | out_valid, out_ready, filtered, interior,   | out
//           | frame_end                                   |
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
//  one pixel per clock unless out_ready stalls the output register
//  the line buffer memory port (one read, one write per cycle) sets the rate
//  reset clears the counters, the pipeline and loads the default registers;
//  line buffers are not cleared
//  a stalled stage holds and stages behind it keep filling bubbles
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire c3f_pkg::pixel_t                     pixel,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output c3f_pkg::out_sum_t                        filtered,
  output logic                                     interior,
  output logic                                     frame_end,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [c3f_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [c3f_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import c3f_pkg::*;

  // configuration registers
  logic [WIDTH_BITS-1:0]  frame_width;
  logic [HEIGHT_BITS-1:0] frame_height;
  logic [KROW_BITS-1:0]   kernel_row [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      kernel_row[0] <= RST_KERNEL_TOP;
      kernel_row[1] <= RST_KERNEL_MIDDLE;
      kernel_row[2] <= RST_KERNEL_BOTTOM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   frame_width   <= cfg_data[WIDTH_BITS-1:0];
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[HEIGHT_BITS-1:0];
        REG_KERNEL_TOP:    kernel_row[0] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_MIDDLE: kernel_row[1] <= cfg_data[KROW_BITS-1:0];
        REG_KERNEL_BOTTOM: kernel_row[2] <= cfg_data[KROW_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  col_t                   w_last;
  row_t                   h_last;

  always_comb begin
    if (frame_width < MIN_WIDTH_VAL) begin
      w_eff = MIN_WIDTH_VAL;
    end else if (frame_width > MAX_WIDTH_VAL) begin
      w_eff = MAX_WIDTH_VAL;
    end else begin
      w_eff = frame_width;
    end
    h_eff  = (frame_height < MIN_HEIGHT_VAL) ? MIN_HEIGHT_VAL : frame_height;
    w_last = COL_BITS'(w_eff - WIDTH_BITS'(1));
    h_last = h_eff - HEIGHT_BITS'(1);
  end

  // pipeline control
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  logic in_fire;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign in_fire  = in_valid && in_ready;

  // position counters
  col_t        col, col_next;
  row_t        row, row_next;
  item_flags_t in_flags;
  logic        row_end;

  always_comb begin
    row_end        = col >= w_last;
    in_flags.last  = row_end && (row >= h_last);
    in_flags.inner = (row >= HEIGHT_BITS'(2)) && (row <= h_last) &&
                     (col >= COL_BITS'(2)) && (col <= w_last);
    if (row_end) begin
      col_next = '0;
      row_next = in_flags.last ? '0 : row + HEIGHT_BITS'(1);
    end else begin
      col_next = col + COL_BITS'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // stage 1: line buffer read
  pixel_t      s1_pixel;
  col_t        s1_col;
  item_flags_t s1_flags, s2_flags, s3_flags, s4_flags;
  line_word_t  rd_word;
  line_word_t  wr_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_fire;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pixel <= pixel;
      s1_col   <= col;
      s1_flags <= in_flags;
    end
    if (en2 && v1) s2_flags <= s1_flags;
    if (en3 && v2) s3_flags <= s2_flags;
    if (en4 && v3) s4_flags <= s3_flags;
  end

  assign wr_word.two_above = rd_word.above;
  assign wr_word.above     = s1_pixel;

  c3f_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (col),
    .rd_data (rd_word),
    .wr_en   (v1 && en2),
    .wr_addr (s1_col),
    .wr_data (wr_word)
  );

  // stages 2 to 4: chain of window column cells
  cell_ctl_t ctl;
  pixel_t    chain [4][3];
  coef_t     cell_coef [3][3];
  colsum_t   col_sum [3];

  assign ctl.shift = v1 && en2;
  assign ctl.mult  = v2 && en3;
  assign ctl.sum   = v3 && en4;

  assign chain[3][0] = rd_word.two_above;
  assign chain[3][1] = rd_word.above;
  assign chain[3][2] = s1_pixel;

  for (genvar kx = 0; kx < 3; kx++) begin : g_cell
    for (genvar ky = 0; ky < 3; ky++) begin : g_coef
      assign cell_coef[kx][ky] = coef_of(kernel_row[ky], kx);
    end

    c3f_col_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .pix_in  (chain[kx+1]),
      .coef    (cell_coef[kx]),
      .pix_out (chain[kx]),
      .col_sum (col_sum[kx])
    );
  end

  // stage 5: output register
  full_sum_t total;

  assign total = full_sum_t'(col_sum[0]) + full_sum_t'(col_sum[1]) +
                 full_sum_t'(col_sum[2]);

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      filtered  <= s4_flags.inner ? OUT_BITS'(total) : '0;
      interior  <= s4_flags.inner;
      frame_end <= s4_flags.last;
    end
  end

endmodule

`default_nettype wire
